@@ rtl/core/frame_psnr_snr_meter_core_assert.svh @@
// Assertion macros for the frame PSNR/SNR meter core.
// Define ASSERT_OFF to compile the checks out.
`ifndef FRAME_PSNR_SNR_METER_CORE_ASSERT_SVH
`define FRAME_PSNR_SNR_METER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FPSM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition");
`define FPSM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`define FPSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`else
`define FPSM_ASSERT_NEVER(lbl, clk, rstn, cond)
`define FPSM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FPSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/fpsm_pkg.sv @@
// Shared types, constants and helpers of the frame PSNR/SNR meter.
// No dependencies.
`default_nettype none
package fpsm_pkg;

  localparam int SMP_W      = 17;
  localparam int PEAK_W     = 16;
  localparam int BLEN_W     = 21;
  localparam int IDX_W      = 32;
  localparam int CNT_W      = 48;
  localparam int SUM_W      = 63;
  localparam int MSE_W      = 40;
  localparam int RMSE_W     = 24;
  localparam int DB_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;
  localparam int LOG_W      = 22;
  localparam int DF_W       = 24;
  localparam int PR_W       = 43;
  localparam int RND_W      = PR_W - 24;
  localparam int DIV_W      = SUM_W + 8;
  localparam int STEP_W     = 7;

  localparam int MAX_BLK_LEN_DEF  = 1048576;
  localparam int SAMPLE_WIDTH_DEF = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEN = 1'd1;

  localparam logic [PEAK_W-1:0] PEAK_RST = 16'd255;
  localparam logic [BLEN_W-1:0] BLEN_RST = 21'd152064;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;
  localparam logic SCOPE_FRAME = 1'b0;
  localparam logic SCOPE_TOTAL = 1'b1;

  localparam logic signed [DB_W-1:0]  DB_ONE     = 16'sd256;
  localparam logic signed [DB_W-1:0]  DB_MIN     = -16'sd32768;
  localparam logic signed [DB_W-1:0]  DB_MAX     = 16'sd32767;
  localparam logic signed [19:0]      DB_SCALE   = 20'sd197283;
  localparam logic signed [PR_W-1:0]  DB_HALF    = 43'sd8388608;
  localparam logic signed [RND_W-1:0] DB_MAX_RND = 19'sd32767;
  localparam logic signed [RND_W-1:0] DB_MIN_RND = -19'sd32768;

  localparam logic [STEP_W-1:0] DIV_LAST  = 7'd70;
  localparam logic [STEP_W-1:0] SQRT_LAST = 7'd23;
  localparam logic [STEP_W-1:0] NORM_LAST = 7'd5;
  localparam logic [STEP_W-1:0] SQ_LAST   = 7'd15;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACC, OP_LOAD, OP_DIV, OP_SQRT_INIT, OP_SQRT, OP_LOG_LOAD,
    OP_LOG_NORM, OP_LOG_SQ, OP_LOG_STORE, OP_DB0, OP_DB1, OP_DB2, OP_CLEAR
  } fpsm_op_t;

  typedef enum logic [1:0] {LOG_EA, LOG_ERR, LOG_PK, LOG_CNT} fpsm_lsel_t;

  typedef struct packed {
    fpsm_op_t   op;
    logic       scope;
    logic       last;
    fpsm_lsel_t lsel;
    logic [2:0] norm_idx;
  } fpsm_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_nonzero;
  } fpsm_sts_t;

  typedef struct packed {
    logic                     scope;
    logic [IDX_W-1:0]         frame_index;
    logic [CNT_W-1:0]         sample_count;
    logic [SUM_W-1:0]         ref_energy;
    logic [SUM_W-1:0]         test_energy;
    logic [SUM_W-1:0]         err_energy;
    logic [MSE_W-1:0]         mse;
    logic [RMSE_W-1:0]        rmse;
    logic signed [DB_W-1:0]   snr_db;
    logic signed [DB_W-1:0]   psnr_db;
    logic                     last;
  } fpsm_res_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W-1:0] x);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {1'b0, x};
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  // round half up to Q8.8 and clamp
  function automatic logic signed [DB_W-1:0] db_sat(input logic signed [PR_W-1:0] p);
    logic signed [PR_W-1:0]  t;
    logic signed [RND_W-1:0] r;
    t = p + DB_HALF;
    r = t[PR_W-1:24];
    if (r > DB_MAX_RND) return DB_MAX;
    if (r < DB_MIN_RND) return DB_MIN;
    return r[DB_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fpsm_in_if.sv @@
// Sample input channel: valid/ready plus one sample pair or flush beat.
// Depends on fpsm_pkg.
`default_nettype none
interface fpsm_in_if import fpsm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [SMP_W-1:0] sample_a;
  logic signed [SMP_W-1:0] sample_b;
  modport source (output valid, kind, sample_a, sample_b, input ready);
  modport sink   (input valid, kind, sample_a, sample_b, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fpsm_out_if.sv @@
// Result channel: valid/ready plus one frame or totals result beat.
// Depends on fpsm_pkg.
`default_nettype none
interface fpsm_out_if import fpsm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   scope;
  logic [IDX_W-1:0]       frame_index;
  logic [CNT_W-1:0]       sample_count;
  logic [SUM_W-1:0]       ref_energy;
  logic [SUM_W-1:0]       test_energy;
  logic [SUM_W-1:0]       err_energy;
  logic [MSE_W-1:0]       mse;
  logic [RMSE_W-1:0]      rmse;
  logic signed [DB_W-1:0] snr_db;
  logic signed [DB_W-1:0] psnr_db;
  logic                   last;
  modport source (output valid, scope, frame_index, sample_count, ref_energy, test_energy,
                  err_energy, mse, rmse, snr_db, psnr_db, last, input ready);
  modport sink   (input valid, scope, frame_index, sample_count, ref_energy, test_energy,
                  err_energy, mse, rmse, snr_db, psnr_db, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fpsm_ctrl.sv @@
// Sequencer: accepts beats, then steps divider, root, log and dB units.
// Depends on fpsm_pkg.
`default_nettype none
module fpsm_ctrl import fpsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  fpsm_sts_t sts,
  output fpsm_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_ACC, S_DRAIN, S_LOAD, S_DIV, S_SQRTI, S_SQRT, S_LOGL, S_LOGN, S_LOGS,
    S_LOGST, S_DB0, S_DB1, S_DB2, S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  fpsm_lsel_t        lsel_r, lsel_nxt;
  logic              scope_r, scope_nxt;
  logic              tot_pend_r, tot_pend_nxt;
  logic              in_ready_r, in_ready_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc;

  assign in_acc    = in_valid && in_ready_r;
  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lsel_nxt      = lsel_r;
    scope_nxt     = scope_r;
    tot_pend_nxt  = tot_pend_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    cmd.scope     = scope_r;
    cmd.last      = (scope_r == SCOPE_TOTAL) || !tot_pend_r;
    cmd.lsel      = lsel_r;
    cmd.norm_idx  = cnt_r[2:0];
    case (state_r)
      S_ACC: begin
        if (in_acc) begin
          if (in_kind == KIND_SAMPLE) begin
            cmd.op = OP_ACC;
            if (sts.pos_last) begin
              scope_nxt    = SCOPE_FRAME;
              tot_pend_nxt = 1'b0;
              in_ready_nxt = 1'b0;
              state_nxt    = S_DRAIN;
            end
          end else begin
            scope_nxt    = sts.pos_nonzero ? SCOPE_FRAME : SCOPE_TOTAL;
            tot_pend_nxt = 1'b1;
            in_ready_nxt = 1'b0;
            state_nxt    = S_DRAIN;
          end
        end
      end
      S_DRAIN: state_nxt = S_LOAD;
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_SQRTI;
      end
      S_SQRTI: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          lsel_nxt  = LOG_EA;
          state_nxt = S_LOGL;
        end
      end
      S_LOGL: begin
        cmd.op    = OP_LOG_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_LOGN;
      end
      S_LOGN: begin
        cmd.op  = OP_LOG_NORM;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NORM_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_LOGS;
        end
      end
      S_LOGS: begin
        cmd.op  = OP_LOG_SQ;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) state_nxt = S_LOGST;
      end
      S_LOGST: begin
        cmd.op    = OP_LOG_STORE;
        state_nxt = S_LOGL;
        case (lsel_r)
          LOG_EA:  lsel_nxt = LOG_ERR;
          LOG_ERR: lsel_nxt = LOG_PK;
          LOG_PK:  lsel_nxt = LOG_CNT;
          default: state_nxt = S_DB0;
        endcase
      end
      S_DB0: begin
        cmd.op    = OP_DB0;
        state_nxt = S_DB1;
      end
      S_DB1: begin
        cmd.op    = OP_DB1;
        state_nxt = S_DB2;
      end
      S_DB2: begin
        cmd.op        = OP_DB2;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (scope_r == SCOPE_FRAME && tot_pend_r) begin
            scope_nxt = SCOPE_TOTAL;
            state_nxt = S_LOAD;
          end else begin
            if (scope_r == SCOPE_TOTAL) cmd.op = OP_CLEAR;
            tot_pend_nxt = 1'b0;
            in_ready_nxt = 1'b1;
            state_nxt    = S_ACC;
          end
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      lsel_r      <= LOG_EA;
      scope_r     <= SCOPE_FRAME;
      tot_pend_r  <= 1'b0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lsel_r      <= lsel_nxt;
      scope_r     <= scope_nxt;
      tot_pend_r  <= tot_pend_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fpsm_dp.sv @@
// Datapath: config registers, accumulators, and the shared serial
// divider, square root, log2 and dB units. Depends on fpsm_pkg.
`default_nettype none
module fpsm_dp import fpsm_pkg::*; #(
  parameter int MAX_BLOCK_LENGTH = MAX_BLK_LEN_DEF,
  parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SMP_W-1:0] in_sample_a,
  input  logic signed [SMP_W-1:0] in_sample_b,
  input  fpsm_cmd_t               cmd,
  output fpsm_sts_t               sts,
  output fpsm_res_t               res
);

  localparam int PW   = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int CW   = ((PW > BLEN_W) ? PW : BLEN_W) + 1;
  localparam int SQ_W = 2 * SAMPLE_WIDTH + 2;

  logic [PEAK_W-1:0] peak_r;
  logic [BLEN_W-1:0] blen_r;

  logic [SUM_W-1:0] fe_a_r, fe_b_r, fe_err_r, te_a_r, te_b_r, te_err_r;
  logic [CNT_W-1:0] tot_cnt_r;
  logic [PW-1:0]    pos_r;
  logic [IDX_W-1:0] fnum_r;
  logic             pipe_vld_r;
  logic [SQ_W-1:0]  sq_a_r, sq_b_r, sq_d_r;

  // sample squares
  logic signed [SAMPLE_WIDTH-1:0] a_s, b_s;
  logic signed [SQ_W-1:0]         a_x, b_x, d_x, aa, bb, dd;
  assign a_s = in_sample_a[SAMPLE_WIDTH-1:0];
  assign b_s = in_sample_b[SAMPLE_WIDTH-1:0];
  assign a_x = SQ_W'(a_s);
  assign b_x = SQ_W'(b_s);
  assign d_x = a_x - b_x;
  assign aa  = a_x * a_x;
  assign bb  = b_x * b_x;
  assign dd  = d_x * d_x;

  // effective frame length
  logic [CW-1:0] blen_x, len_eff, pos_inc;
  assign blen_x  = CW'(blen_r);
  assign len_eff = (blen_r == '0) ? CW'(1) :
                   (blen_x > CW'(MAX_BLOCK_LENGTH)) ? CW'(MAX_BLOCK_LENGTH) : blen_x;
  assign pos_inc = CW'(pos_r) + CW'(1);
  assign sts.pos_last    = pos_inc >= len_eff;
  assign sts.pos_nonzero = pos_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r     <= PEAK_RST;
      blen_r     <= BLEN_RST;
      fe_a_r     <= '0;
      fe_b_r     <= '0;
      fe_err_r   <= '0;
      te_a_r     <= '0;
      te_b_r     <= '0;
      te_err_r   <= '0;
      tot_cnt_r  <= '0;
      pos_r      <= '0;
      fnum_r     <= '0;
      pipe_vld_r <= 1'b0;
    end else begin
      pipe_vld_r <= (cmd.op == OP_ACC);
      if (cmd.op == OP_ACC) begin
        pos_r     <= pos_inc[PW-1:0];
        tot_cnt_r <= (&tot_cnt_r) ? tot_cnt_r : tot_cnt_r + 1'b1;
      end
      if (cmd.op == OP_CLEAR) begin
        fe_a_r    <= '0;
        fe_b_r    <= '0;
        fe_err_r  <= '0;
        te_a_r    <= '0;
        te_b_r    <= '0;
        te_err_r  <= '0;
        tot_cnt_r <= '0;
        pos_r     <= '0;
        fnum_r    <= '0;
      end else if (cmd.op == OP_LOAD && cmd.scope == SCOPE_FRAME) begin
        fe_a_r   <= '0;
        fe_b_r   <= '0;
        fe_err_r <= '0;
        pos_r    <= '0;
        fnum_r   <= fnum_r + 1'b1;
      end else if (pipe_vld_r) begin
        fe_a_r   <= sat_add(fe_a_r,   SUM_W'(sq_a_r));
        fe_b_r   <= sat_add(fe_b_r,   SUM_W'(sq_b_r));
        fe_err_r <= sat_add(fe_err_r, SUM_W'(sq_d_r));
        te_a_r   <= sat_add(te_a_r,   SUM_W'(sq_a_r));
        te_b_r   <= sat_add(te_b_r,   SUM_W'(sq_b_r));
        te_err_r <= sat_add(te_err_r, SUM_W'(sq_d_r));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PEAK: peak_r <= cfg_data[PEAK_W-1:0];
          CFG_BLEN: blen_r <= cfg_data[BLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result work registers
  logic                    w_scope, w_last, w_zero;
  logic [IDX_W-1:0]        w_idx;
  logic [CNT_W-1:0]        w_cnt;
  logic [SUM_W-1:0]        w_ea, w_eb, w_err;
  logic [DIV_W-1:0]        div_num_r;
  logic [CNT_W-1:0]        div_rem_r;
  logic [MSE_W-1:0]        mse_r;
  logic [2*RMSE_W-1:0]     sq_v_r;
  logic [RMSE_W:0]         sq_rem_r;
  logic [RMSE_W-1:0]       sq_root_r;
  logic [63:0]             lg_v_r;
  logic [5:0]              lg_e_r;
  logic [15:0]             lg_frac_r;
  logic [LOG_W-1:0]        lg_ea_r, lg_err_r, lg_pk_r, lg_cnt_r;
  logic signed [PR_W-1:0]  prod_r;
  logic signed [DB_W-1:0]  snr_r, psnr_r;

  logic [CNT_W-1:0] ld_cnt;
  logic [SUM_W-1:0] ld_ea, ld_eb, ld_err;
  assign ld_cnt = (cmd.scope == SCOPE_FRAME) ? CNT_W'(pos_r) : tot_cnt_r;
  assign ld_ea  = (cmd.scope == SCOPE_FRAME) ? fe_a_r : te_a_r;
  assign ld_eb  = (cmd.scope == SCOPE_FRAME) ? fe_b_r : te_b_r;
  assign ld_err = (cmd.scope == SCOPE_FRAME) ? fe_err_r : te_err_r;

  // restoring divide step
  logic [CNT_W:0] div_sh;
  logic           div_ge;
  assign div_sh = {div_rem_r, div_num_r[DIV_W-1]};
  assign div_ge = div_sh >= {1'b0, w_cnt};

  logic [MSE_W-1:0] mse_val;
  assign mse_val = w_zero ? '0 :
                   (|div_num_r[DIV_W-1:MSE_W]) ? {MSE_W{1'b1}} : div_num_r[MSE_W-1:0];

  // square root step
  logic [RMSE_W+2:0] sq_sh, sq_trial;
  logic              sq_ge;
  assign sq_sh    = {sq_rem_r, sq_v_r[2*RMSE_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // log2 normalize and squaring steps
  logic [PEAK_W-1:0] pk;
  logic [31:0]       pk_sq;
  logic [63:0]       lg_op, lg_mask, m_sq;
  logic [6:0]        nsh;
  assign pk      = (peak_r == '0) ? PEAK_W'(1) : peak_r;
  assign pk_sq   = pk * pk;
  assign nsh     = 7'd32 >> cmd.norm_idx;
  assign lg_mask = ~({64{1'b1}} >> nsh);
  assign m_sq    = lg_v_r[63:32] * lg_v_r[63:32];

  always_comb begin
    case (cmd.lsel)
      LOG_EA:  lg_op = 64'(w_ea);
      LOG_ERR: lg_op = 64'(w_err);
      LOG_PK:  lg_op = 64'(pk_sq);
      default: lg_op = 64'(w_cnt);
    endcase
  end

  logic signed [DF_W-1:0] snr_diff, psnr_diff;
  logic signed [PR_W-1:0] snr_prod, psnr_prod;
  assign snr_diff  = DF_W'(lg_ea_r) - DF_W'(lg_err_r);
  assign psnr_diff = DF_W'(lg_pk_r) + DF_W'(lg_cnt_r) - DF_W'(lg_err_r);
  assign snr_prod  = snr_diff * DB_SCALE;
  assign psnr_prod = psnr_diff * DB_SCALE;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACC) begin
      sq_a_r <= aa;
      sq_b_r <= bb;
      sq_d_r <= dd;
    end
    case (cmd.op)
      OP_LOAD: begin
        w_scope   <= cmd.scope;
        w_last    <= cmd.last;
        w_idx     <= fnum_r;
        w_cnt     <= ld_cnt;
        w_ea      <= ld_ea;
        w_eb      <= ld_eb;
        w_err     <= ld_err;
        w_zero    <= (ld_err == '0) || (ld_cnt == '0);
        div_num_r <= {ld_err, 8'd0};
        div_rem_r <= '0;
      end
      OP_DIV: begin
        div_rem_r <= div_ge ? CNT_W'(div_sh - {1'b0, w_cnt}) : div_sh[CNT_W-1:0];
        div_num_r <= {div_num_r[DIV_W-2:0], div_ge};
      end
      OP_SQRT_INIT: begin
        mse_r     <= mse_val;
        sq_v_r    <= {mse_val, 8'd0};
        sq_rem_r  <= '0;
        sq_root_r <= '0;
      end
      OP_SQRT: begin
        sq_rem_r  <= sq_ge ? (RMSE_W+1)'(sq_sh - sq_trial) : sq_sh[RMSE_W:0];
        sq_root_r <= {sq_root_r[RMSE_W-2:0], sq_ge};
        sq_v_r    <= {sq_v_r[2*RMSE_W-3:0], 2'b00};
      end
      OP_LOG_LOAD: begin
        lg_v_r    <= lg_op;
        lg_e_r    <= 6'd63;
        lg_frac_r <= '0;
      end
      OP_LOG_NORM: begin
        if ((lg_v_r & lg_mask) == '0) begin
          lg_v_r <= lg_v_r << nsh;
          lg_e_r <= lg_e_r - nsh[5:0];
        end
      end
      OP_LOG_SQ: begin
        lg_frac_r <= {lg_frac_r[14:0], m_sq[63]};
        lg_v_r    <= {(m_sq[63] ? m_sq[63:32] : m_sq[62:31]), 32'd0};
      end
      OP_LOG_STORE: begin
        case (cmd.lsel)
          LOG_EA:  lg_ea_r  <= {lg_e_r, lg_frac_r};
          LOG_ERR: lg_err_r <= {lg_e_r, lg_frac_r};
          LOG_PK:  lg_pk_r  <= {lg_e_r, lg_frac_r};
          default: lg_cnt_r <= {lg_e_r, lg_frac_r};
        endcase
      end
      OP_DB0: prod_r <= snr_prod;
      OP_DB1: begin
        snr_r  <= (w_ea == '0) ? DB_MIN : db_sat(prod_r);
        prod_r <= psnr_prod;
      end
      OP_DB2: psnr_r <= db_sat(prod_r);
      default: ;
    endcase
  end

  assign res.scope        = w_scope;
  assign res.frame_index  = w_idx;
  assign res.sample_count = w_cnt;
  assign res.ref_energy   = w_ea;
  assign res.test_energy  = w_eb;
  assign res.err_energy   = w_err;
  assign res.mse          = mse_r;
  assign res.rmse         = w_zero ? '0 : sq_root_r;
  assign res.snr_db       = w_zero ? DB_ONE : snr_r;
  assign res.psnr_db      = w_zero ? DB_ONE : psnr_r;
  assign res.last         = w_last;

endmodule
`default_nettype wire

@@ rtl/core/frame_psnr_snr_meter_core.sv @@
// Frame PSNR/SNR meter top: sample beats in, one result beat per frame end,
// and per flush a partial-frame beat (if samples are pending) plus one totals beat.
// Sample beats without a frame end: one per cycle. Frame end or flush: the result
// comes from the 71-step divider, 24-step root and four log2 runs; the totals beat
// of a flush follows a partial-frame beat once that beat is taken.
// rst_n (synchronous) clears all sums and counters; peak=255, length=152064.
`default_nettype none
`include "frame_psnr_snr_meter_core_assert.svh"
module frame_psnr_snr_meter_core import fpsm_pkg::*; #(
  parameter int MAX_BLOCK_LENGTH = MAX_BLK_LEN_DEF,
  parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fpsm_in_if.sink               in_if,
  fpsm_out_if.source            out_if
);

  fpsm_cmd_t cmd;
  fpsm_sts_t sts;
  fpsm_res_t res;
  logic      in_ready, out_valid, out_ready;

  assign out_ready = out_if.ready;

  fpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_kind   (in_if.kind),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpsm_dp #(
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sample_a (in_if.sample_a),
    .in_sample_b (in_if.sample_b),
    .cmd         (cmd),
    .sts         (sts),
    .res         (res)
  );

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid;
  assign out_if.scope         = res.scope;
  assign out_if.frame_index   = res.frame_index;
  assign out_if.sample_count  = res.sample_count;
  assign out_if.ref_energy    = res.ref_energy;
  assign out_if.test_energy   = res.test_energy;
  assign out_if.err_energy    = res.err_energy;
  assign out_if.mse           = res.mse;
  assign out_if.rmse          = res.rmse;
  assign out_if.snr_db        = res.snr_db;
  assign out_if.psnr_db       = res.psnr_db;
  assign out_if.last          = res.last;

  `FPSM_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid)
  `FPSM_ASSERT_IMPL(a_total_last, clk, rst_n, out_valid && res.scope == SCOPE_TOTAL, res.last)
  `FPSM_ASSERT_IMPL(a_zero_err, clk, rst_n, out_valid && res.err_energy == '0, res.mse == '0)
  `FPSM_ASSERT_NEXT(a_resume, clk, rst_n, out_valid && out_ready && res.scope == SCOPE_TOTAL, in_ready)

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for frame_psnr_snr_meter_core: drives sample/flush beats,
// predicts per-frame and stream-total results, checks every result beat.
// Depends on fpsm_pkg, fpsm_in_if, fpsm_out_if and the core RTL.
`default_nettype none
module tb;
  import fpsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SUM_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned CNT_SAT = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned MSE_SAT = 64'h0000_00FF_FFFF_FFFF;
  localparam longint unsigned LEN_CAP = 1048576;
  localparam int SETTLE = 450;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpsm_in_if  in_if ();
  fpsm_out_if out_if ();

  frame_psnr_snr_meter_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_if(in_if.sink), .out_if(out_if.source)
  );

  // predicted meter state
  logic [PEAK_W-1:0] cur_peak;
  logic [BLEN_W-1:0] cur_blen;
  longint unsigned fr_ea, fr_eb, fr_err, fr_pos;
  logic [31:0] fr_num;
  longint unsigned tot_ea, tot_eb, tot_err, tot_cnt;

  fpsm_res_t pending_results[$];
  int errors = 0;
  bit calm = 0;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  initial begin
    #100ms;
    $display("frame_psnr_snr_meter_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= calm || ($urandom_range(99) >= 14);
  end

  function automatic longint unsigned sat_sum(longint unsigned s, longint unsigned x,
                                              longint unsigned lim);
    if (x > lim || s > lim - x) return lim;
    return s + x;
  endfunction

  function automatic longint log2_fix(longint unsigned v);
    int e;
    longint unsigned m;
    longint f;
    e = 63;
    f = 0;
    while (e > 0 && !v[e]) e--;
    if (e >= 31) m = v >> (e - 31);
    else m = v << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        f = f | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 16) + f;
  endfunction

  function automatic logic [15:0] to_db(longint d);
    longint p;
    longint r;
    p = d * 197283 + (longint'(1) << 23);
    if (p >= 0) r = p / (longint'(1) << 24);
    else r = -((-p + ((longint'(1) << 24) - 1)) / (longint'(1) << 24));
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic fpsm_res_t meter_result(logic sc, logic [31:0] idx, longint unsigned cnt,
                                             longint unsigned ea, longint unsigned eb,
                                             longint unsigned err, logic lst);
    fpsm_res_t r;
    longint unsigned q, rem, mse, pk;
    logic [15:0] snr, psnr;
    mse = 0;
    snr = 16'd256;
    psnr = 16'd256;
    pk = (cur_peak != 0) ? longint'(cur_peak) : 1;
    if (err != 0 && cnt != 0) begin
      q = err / cnt;
      rem = err % cnt;
      if (q >= 64'h1_0000_0000) mse = MSE_SAT;
      else begin
        mse = (q << 8) + (rem << 8) / cnt;
        if (mse > MSE_SAT) mse = MSE_SAT;
      end
      if (ea == 0) snr = 16'h8000;
      else snr = to_db(log2_fix(ea) - log2_fix(err));
      psnr = to_db(log2_fix(pk * pk) + log2_fix(cnt) - log2_fix(err));
    end
    r.scope = sc;
    r.frame_index = idx;
    r.sample_count = cnt[CNT_W-1:0];
    r.ref_energy = ea[SUM_W-1:0];
    r.test_energy = eb[SUM_W-1:0];
    r.err_energy = err[SUM_W-1:0];
    r.mse = mse[MSE_W-1:0];
    r.rmse = RMSE_W'(int_sqrt(mse << 8));
    r.snr_db = snr;
    r.psnr_db = psnr;
    r.last = lst;
    return r;
  endfunction

  task automatic clear_meter(bit whole);
    fr_ea = 0; fr_eb = 0; fr_err = 0; fr_pos = 0;
    if (whole) begin
      fr_num = 0; tot_ea = 0; tot_eb = 0; tot_err = 0; tot_cnt = 0;
    end
  endtask

  task automatic predict_beat(logic kind, logic signed [SMP_W-1:0] sa,
                              logic signed [SMP_W-1:0] sb);
    longint a, b, d;
    longint unsigned len;
    if (kind == KIND_FLUSH) begin
      if (fr_pos > 0) begin
        pending_results.push_back(meter_result(SCOPE_FRAME, fr_num, fr_pos, fr_ea, fr_eb,
                                               fr_err, 1'b0));
        fr_num++;
      end
      pending_results.push_back(meter_result(SCOPE_TOTAL, fr_num, tot_cnt, tot_ea, tot_eb,
                                             tot_err, 1'b1));
      clear_meter(1);
    end else begin
      a = sa;
      b = sb;
      d = a - b;
      len = cur_blen;
      if (len == 0) len = 1;
      if (len > LEN_CAP) len = LEN_CAP;
      fr_ea = sat_sum(fr_ea, a * a, SUM_SAT);
      fr_eb = sat_sum(fr_eb, b * b, SUM_SAT);
      fr_err = sat_sum(fr_err, d * d, SUM_SAT);
      tot_ea = sat_sum(tot_ea, a * a, SUM_SAT);
      tot_eb = sat_sum(tot_eb, b * b, SUM_SAT);
      tot_err = sat_sum(tot_err, d * d, SUM_SAT);
      tot_cnt = sat_sum(tot_cnt, 1, CNT_SAT);
      fr_pos++;
      if (fr_pos >= len) begin
        pending_results.push_back(meter_result(SCOPE_FRAME, fr_num, fr_pos, fr_ea, fr_eb,
                                               fr_err, 1'b1));
        fr_num++;
        clear_meter(0);
      end
    end
  endtask

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    fpsm_res_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report("result beat with nothing pending");
      end else begin
        w = pending_results.pop_front();
        check_field("scope", out_if.scope, w.scope);
        check_field("frame_index", out_if.frame_index, w.frame_index);
        check_field("sample_count", out_if.sample_count, w.sample_count);
        check_field("ref_energy", out_if.ref_energy, w.ref_energy);
        check_field("test_energy", out_if.test_energy, w.test_energy);
        check_field("err_energy", out_if.err_energy, w.err_energy);
        check_field("mse", out_if.mse, w.mse);
        check_field("rmse", out_if.rmse, w.rmse);
        check_field("snr_db", out_if.snr_db, w.snr_db);
        check_field("psnr_db", out_if.psnr_db, w.psnr_db);
        check_field("last", out_if.last, w.last);
      end
    end
  end

  // leaves valid high unless it inserts a random gap; the caller sends again in the same step or calls hold_input
  task automatic send_beat(logic kind, logic signed [SMP_W-1:0] sa,
                           logic signed [SMP_W-1:0] sb);
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.sample_a <= sa;
    in_if.sample_b <= sb;
    do @(posedge clk); while (!in_if.ready);
    predict_beat(kind, sa, sb);
    if (!calm && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic hold_input();
    in_if.valid <= 1'b0;
  endtask

  task automatic settle();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PEAK) cur_peak = val[PEAK_W-1:0];
    else cur_blen = val;
  endtask

  task automatic sample(logic signed [SMP_W-1:0] sa, logic signed [SMP_W-1:0] sb);
    send_beat(KIND_SAMPLE, sa, sb);
  endtask

  task automatic flush();
    send_beat(KIND_FLUSH, SMP_W'($urandom), SMP_W'($urandom));
  endtask

  task automatic test_empty_flush();
    flush();
    settle();
  endtask

  task automatic test_extremes_len0_peak0();
    write_reg(CFG_PEAK, '0);
    write_reg(CFG_BLEN, '0);
    sample(17'sd65535, -17'sd32768);
    sample(-17'sd32768, 17'sd65535);
    sample(17'h10000, 17'h0FFFF);
    sample('0, '0);
    sample('0, 17'sd5);
    sample(17'sd1234, 17'sd1234);
    sample(17'h1FFFF, 17'h00001);
    flush();
    settle();
  endtask

  task automatic test_long_frame_partial();
    write_reg(CFG_PEAK, 21'hFFFF);
    write_reg(CFG_BLEN, 21'h1FFFFF);
    sample(17'sd100, 17'sd90);
    sample(-17'sd7, 17'sd3);
    sample(17'sd65535, 17'sd65535);
    flush();
    settle();
    write_reg(CFG_BLEN, 21'd1048576);
    sample(17'sd40000, -17'sd20000);
    sample(17'sd1, 17'sd2);
    flush();
    settle();
  endtask

  task automatic test_length_lowered();
    write_reg(CFG_PEAK, 21'd255);
    write_reg(CFG_BLEN, 21'd8);
    for (int i = 0; i < 5; i++) sample(SMP_W'($urandom), SMP_W'($urandom));
    settle();
    write_reg(CFG_BLEN, 21'd3);
    sample(17'sd9, -17'sd9);
    sample(17'sd4, 17'sd4);
    sample(17'sd4, 17'sd4);
    sample(17'sd4, 17'sd4);
    flush();
    settle();
  endtask

  task automatic random_pair(output logic signed [SMP_W-1:0] sa,
                             output logic signed [SMP_W-1:0] sb);
    int pick;
    pick = $urandom_range(99);
    sa = SMP_W'($urandom);
    if (pick < 20) sb = sa;
    else if (pick < 45) sb = sa + $signed(17'($urandom_range(8))) - 17'sd4;
    else if (pick < 55) begin
      sa = '0;
      sb = SMP_W'($urandom);
    end else sb = SMP_W'($urandom);
  endtask

  task automatic test_random_phase(int n, bit quiet);
    logic signed [SMP_W-1:0] sa, sb;
    int pk_pick, len_pick;
    pk_pick = $urandom_range(3);
    len_pick = $urandom_range(9);
    case (pk_pick)
      0: write_reg(CFG_PEAK, 21'd1);
      1: write_reg(CFG_PEAK, 21'd255);
      2: write_reg(CFG_PEAK, 21'hFFFF);
      default: write_reg(CFG_PEAK, CFG_DATA_W'($urandom_range(65535)));
    endcase
    if (len_pick == 0) write_reg(CFG_BLEN, 21'd1);
    else if (len_pick == 1) write_reg(CFG_BLEN, 21'd1048576);
    else write_reg(CFG_BLEN, CFG_DATA_W'($urandom_range(12, 2)));
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) flush();
      else begin
        random_pair(sa, sb);
        sample(sa, sb);
      end
    end
    flush();
    settle();
    calm = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PEAK;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.kind <= KIND_SAMPLE;
    in_if.sample_a <= '0;
    in_if.sample_b <= '0;
    cur_peak = PEAK_RST;
    cur_blen = BLEN_RST;
    clear_meter(1);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_flush();
    test_extremes_len0_peak0();
    test_long_frame_partial();
    test_length_lowered();
    for (int p = 0; p < 6; p++) test_random_phase(155, p == 2);

    hold_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("frame_psnr_snr_meter_core verification clean");
    else
      $display("frame_psnr_snr_meter_core verification failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/fpsm_pkg.sv
rtl/core/fpsm_in_if.sv
rtl/core/fpsm_out_if.sv
rtl/core/fpsm_ctrl.sv
rtl/core/fpsm_dp.sv
rtl/core/frame_psnr_snr_meter_core.sv
bench/tb.sv
